/* rtl/uam_pkg.sv */
// ----------------------------------------------------------------------------
// uam_pkg
// Shared types and constants for the undirected adjacency matrix block.
// ----------------------------------------------------------------------------
package uam_pkg;

  // graph size and derived widths
  localparam int unsigned MaxVertices = 8;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = VtxW + 1;
  localparam int unsigned DegW        = 4;
  localparam int unsigned EdgeW       = 6;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2,
    OP_DEGREE = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // input word
  typedef struct packed {
    logic [1:0]      operation;
    logic [VtxW-1:0] vertex_a;
    logic [VtxW-1:0] vertex_b;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [1:0]       status;
    logic [VtxW-1:0]  edge_from;
    logic [VtxW-1:0]  edge_to;
    logic [EdgeW-1:0] edge_total;
    logic [DegW-1:0]  degree_value;
    logic             last_result;
  } out_word_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_UPD_A,
    S_UPD_B,
    S_RESP,
    S_SCAN,
    S_FLUSH
  } state_e;

  // kind of word written to the output register
  typedef enum logic [1:0] {
    EMIT_PEND,
    EMIT_EMPTY,
    EMIT_RANGE,
    EMIT_DEG
  } emit_e;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  upd_a;
    logic  upd_b;
    logic  scan_adv;
    logic  pend_load;
    logic  emit;
    logic  emit_last;
    emit_e emit_sel;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_list;
    logic range_err;
    logic need_upd;
    logic scan_end;
    logic scan_hit;
    logic pend_valid;
    logic out_free;
  } ctrl_sts_t;

endpackage

/* rtl/uam_dp.sv */
// ----------------------------------------------------------------------------
// uam_dp
// Datapath: adjacency rows, degree counters, edge counter, list scan
// pointers, pending edge and the output register.
// ----------------------------------------------------------------------------
module uam_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  input  uam_pkg::in_word_t   in_word_i,
  input  uam_pkg::ctrl_cmd_t  cmd_i,
  output uam_pkg::ctrl_sts_t  sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output uam_pkg::out_word_t  out_word_o
);
  import uam_pkg::*;

  logic [3:0]            vcount_q;
  logic [1:0]            op_q;
  logic [VtxW-1:0]       a_q, b_q;
  logic [MaxVertices-1:0] rows_q [MaxVertices];
  logic [DegW-1:0]       deg_q  [MaxVertices];
  logic [EdgeW-1:0]      edges_q;
  logic [CntW-1:0]       v_q, w_q;
  logic                  pend_valid_q;
  logic [VtxW-1:0]       pend_from_q, pend_to_q;
  logic                  out_valid_q;
  out_word_t             out_q, out_d;

  logic [CntW-1:0]       n_act;
  logic                  is_list, set_bit;
  logic [VtxW-1:0]       row_addr, col_addr, deg_addr, wr_row, wr_col;
  logic                  cell_bit;
  logic [DegW-1:0]       deg_rd;
  logic                  w_out, out_free;

  // active vertex count, clamped to the matrix size
  assign n_act = (vcount_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : CntW'(vcount_q);

  assign is_list = (op_q == OP_LIST);
  assign set_bit = (op_q == OP_INSERT);

  // single row read port, shared by the update check and the list scan
  assign row_addr = is_list ? v_q[VtxW-1:0] : a_q;
  assign col_addr = is_list ? w_q[VtxW-1:0] : b_q;
  assign cell_bit = rows_q[row_addr][col_addr];

  // single degree read port
  assign deg_addr = cmd_i.upd_b ? b_q : a_q;
  assign deg_rd   = deg_q[deg_addr];

  // mirrored write address
  assign wr_row = cmd_i.upd_b ? b_q : a_q;
  assign wr_col = cmd_i.upd_b ? a_q : b_q;

  assign w_out    = (w_q >= n_act);
  assign out_free = !out_valid_q || out_ready_i;

  // status to controller
  always_comb begin
    sts_o            = '0;
    sts_o.is_list    = is_list;
    sts_o.range_err  = ({1'b0, a_q} >= n_act) ||
                       ((op_q != OP_DEGREE) && ({1'b0, b_q} >= n_act));
    sts_o.need_upd   = ((op_q == OP_INSERT) && !cell_bit) ||
                       ((op_q == OP_REMOVE) && cell_bit);
    sts_o.scan_end   = w_out && ((v_q + CntW'(1)) >= n_act);
    sts_o.scan_hit   = !w_out && cell_bit;
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 4'(MaxVertices);
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // captured input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_word_i.operation;
      a_q  <= in_word_i.vertex_a;
      b_q  <= in_word_i.vertex_b;
    end
  end

  // matrix, degrees and edge count; one matrix bit and one degree written per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxVertices; i++) begin
        rows_q[i] <= '0;
        deg_q[i]  <= '0;
      end
      edges_q <= '0;
    end else if (cmd_i.upd_a || cmd_i.upd_b) begin
      rows_q[wr_row][wr_col] <= set_bit;
      deg_q[deg_addr]        <= set_bit ? deg_rd + DegW'(1) : deg_rd - DegW'(1);
      if (cmd_i.upd_a) begin
        edges_q <= set_bit ? edges_q + EdgeW'(1) : edges_q - EdgeW'(1);
      end
    end
  end

  // list scan pointers over the upper triangle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= '0;
      w_q <= CntW'(1);
    end else if (cmd_i.scan_adv) begin
      if (w_out) begin
        v_q <= v_q + CntW'(1);
        w_q <= v_q + CntW'(2);
      end else begin
        w_q <= w_q + CntW'(1);
      end
    end
  end

  // pending edge, held back until it is known whether it is the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.pend_load) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_from_q <= v_q[VtxW-1:0];
      pend_to_q   <= w_q[VtxW-1:0];
    end
  end

  // output word selection
  always_comb begin
    out_d              = '0;
    out_d.edge_total   = edges_q;
    out_d.last_result  = 1'b1;
    case (cmd_i.emit_sel)
      EMIT_PEND: begin
        out_d.status      = ST_OK;
        out_d.edge_from   = pend_from_q;
        out_d.edge_to     = pend_to_q;
        out_d.last_result = cmd_i.emit_last;
      end
      EMIT_EMPTY: out_d.status = ST_EMPTY;
      EMIT_RANGE: out_d.status = ST_RANGE;
      EMIT_DEG: begin
        out_d.status       = ST_OK;
        out_d.degree_value = deg_rd;
      end
      default: out_d.status = ST_OK;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/uam_ctrl.sv */
// ----------------------------------------------------------------------------
// uam_ctrl
// Controller: sequences check, mirrored update, response and list scan.
// ----------------------------------------------------------------------------
module uam_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  uam_pkg::ctrl_sts_t  sts_i,
  output uam_pkg::ctrl_cmd_t  cmd_o
);
  import uam_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.is_list) state_d = S_SCAN;
        else if (sts_i.range_err) state_d = S_RESP;
        else if (sts_i.need_upd) state_d = S_UPD_A;
        else state_d = S_RESP;
      end
      S_UPD_A: state_d = S_UPD_B;
      S_UPD_B: state_d = S_RESP;
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (sts_i.scan_end) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_UPD_A: cmd_o.upd_a = 1'b1;
      S_UPD_B: cmd_o.upd_b = 1'b1;
      S_RESP: begin
        cmd_o.emit     = sts_i.out_free;
        cmd_o.emit_sel = sts_i.range_err ? EMIT_RANGE : EMIT_DEG;
      end
      S_SCAN: begin
        // a new hit pushes the previous one out, so it may wait on the output
        if (!sts_i.scan_end) begin
          if (!sts_i.scan_hit) begin
            cmd_o.scan_adv = 1'b1;
          end else if (!sts_i.pend_valid || sts_i.out_free) begin
            cmd_o.scan_adv  = 1'b1;
            cmd_o.pend_load = 1'b1;
            cmd_o.emit      = sts_i.pend_valid;
            cmd_o.emit_sel  = EMIT_PEND;
          end
        end
      end
      S_FLUSH: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_last = 1'b1;
        cmd_o.emit_sel  = sts_i.pend_valid ? EMIT_PEND : EMIT_EMPTY;
      end
      default: cmd_o = '0;
    endcase
  end

  // never overwrite a word still waiting at the output
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("output word overwritten");

  // the mirrored half always follows the first half
  a_upd_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd_a |=> cmd_o.upd_b)
    else $error("mirrored update missing");

  // an accepted word always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted word not processed");

  // a list word ends with a final result as soon as the output is free
  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && sts_i.out_free) |-> (cmd_o.emit && cmd_o.emit_last))
    else $error("list finished without final word");

endmodule

/* rtl/undirected_adjacency_matrix.sv */
// ----------------------------------------------------------------------------
// undirected_adjacency_matrix
// Undirected graph kept as a symmetric bit matrix with vertex degrees and an
// edge count; insert, remove, degree query and edge listing.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_ready_o    in_word_i  (in_word_t)
//  out       output     out_valid_o / out_ready_i  out_word_o (out_word_t)
//  cfg       input      cfg_we_i                   cfg_wdata_i (vertex count)
//
//  Insert or remove that changes the matrix: check, both mirrored updates and
//  response; other inserts, removes, degree queries and range errors: check and
//  response. List: check, then a row-by-row scan of the upper triangle through
//  the single row read port, then the final word. New words enter only in idle.
//  Reset clears matrix, degrees and edge count at once; no clearing pass.
//  A full output register stalls the response, the final list word, or the
//  scan at its next hit.
// ----------------------------------------------------------------------------
module undirected_adjacency_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uam_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output uam_pkg::out_word_t out_word_o
);
  import uam_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  uam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and result path
  uam_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
